FILE: hdl/rgpg_pkg.sv
`timescale 1ns / 1ps
package rgpg_pkg;
    localparam int unsigned PIX_W         = 12;
    localparam int unsigned DIM_W         = 13;
    localparam int unsigned CHAN_W        = 8;
    localparam int unsigned MAX_DIMENSION = 4096;
    // squared doubled offsets and their sum
    localparam int unsigned SQ_W          = 2 * DIM_W;
    localparam int unsigned SUM_W         = SQ_W + 1;
    localparam int unsigned APB_AW        = 3;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = '1;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic zero;   // one by one image
        logic sat;    // at or beyond the corner
    } rgpg_flags_t;

    typedef struct packed
    {
        logic en;     // advance every stage
        logic vld;    // beat entering the unit
    } rgpg_ctl_t;
endpackage

FILE: hdl/rgpg_pix_if.sv
`timescale 1ns / 1ps
interface rgpg_pix_if
    import rgpg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;

    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

FILE: hdl/rgpg_rgba_if.sv
`timescale 1ns / 1ps
interface rgpg_rgba_if
    import rgpg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

FILE: hdl/rgpg_geom.sv
`timescale 1ns / 1ps
module rgpg_geom
    import rgpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rgpg_ctl_t        ctl,
    input  logic [PIX_W-1:0] px,
    input  logic [PIX_W-1:0] py,
    input  logic [DIM_W-1:0] width_raw,
    input  logic [DIM_W-1:0] height_raw,
    output logic             vld,
    output logic [SUM_W-1:0] num,
    output logic [SUM_W-1:0] den,
    output rgpg_flags_t      flags
);
    logic [DIM_W-1:0] weff;
    logic [DIM_W-1:0] heff;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic [DIM_W-1:0] tx;
    logic [DIM_W-1:0] ty;

    logic [2:0]       vld_reg;
    logic [DIM_W-1:0] mx_reg;
    logic [DIM_W-1:0] my_reg;
    logic [DIM_W-1:0] cx_reg;
    logic [DIM_W-1:0] cy_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [SQ_W-1:0]  sqcx_reg;
    logic [SQ_W-1:0]  sqcy_reg;
    logic [SUM_W-1:0] num_reg;
    logic [SUM_W-1:0] den_reg;
    rgpg_flags_t      flags_reg;
    logic [SUM_W-1:0] num_next;
    logic [SUM_W-1:0] den_next;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
        logic [DIM_W-1:0] v;
        v = (raw == '0) ? DIM_W'(1) : raw;
        if (32'(v) > MAX_DIMENSION)
        begin
            v = DIM_W'(MAX_DIMENSION);
        end
        return v;
    endfunction

    always_comb
    begin
        weff = eff_dim(width_raw);
        heff = eff_dim(height_raw);
        cx   = weff - DIM_W'(1);
        cy   = heff - DIM_W'(1);
        tx   = {px, 1'b0};
        ty   = {py, 1'b0};
        num_next = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        den_next = SUM_W'(sqcx_reg) + SUM_W'(sqcy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[1:0], ctl.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            mx_reg    <= (tx >= cx) ? (tx - cx) : (cx - tx);
            my_reg    <= (ty >= cy) ? (ty - cy) : (cy - ty);
            cx_reg    <= cx;
            cy_reg    <= cy;
            sqx_reg   <= SQ_W'(mx_reg) * SQ_W'(mx_reg);
            sqy_reg   <= SQ_W'(my_reg) * SQ_W'(my_reg);
            sqcx_reg  <= SQ_W'(cx_reg) * SQ_W'(cx_reg);
            sqcy_reg  <= SQ_W'(cy_reg) * SQ_W'(cy_reg);
            num_reg   <= num_next;
            den_reg   <= den_next;
            flags_reg <= '{zero: (den_next == '0), sat: (num_next >= den_next)};
        end
    end

    assign vld   = vld_reg[2];
    assign num   = num_reg;
    assign den   = den_reg;
    assign flags = flags_reg;
endmodule

FILE: hdl/rgpg_div.sv
`timescale 1ns / 1ps
module rgpg_div
    import rgpg_pkg::*;
#(
    parameter int unsigned QW = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rgpg_ctl_t        ctl,
    input  logic [SUM_W-1:0] num,
    input  logic [SUM_W-1:0] den,
    input  rgpg_flags_t      flags_in,
    output logic             vld,
    output logic [QW-1:0]    quo,
    output rgpg_flags_t      flags
);
    // one quotient bit per stage, remainder stays below den while num is below den
    logic             vld_reg   [1:QW];
    logic [SUM_W-1:0] rem_reg   [1:QW];
    logic [SUM_W-1:0] den_reg   [1:QW];
    logic [QW-1:0]    quo_reg   [1:QW];
    rgpg_flags_t      flags_reg [1:QW];

    logic             vld_in    [0:QW-1];
    logic [SUM_W-1:0] rem_in    [0:QW-1];
    logic [SUM_W-1:0] den_in    [0:QW-1];
    logic [QW-1:0]    quo_in    [0:QW-1];
    rgpg_flags_t      flags_in_s[0:QW-1];

    assign vld_in[0]     = ctl.vld;
    assign rem_in[0]     = num;
    assign den_in[0]     = den;
    assign quo_in[0]     = '0;
    assign flags_in_s[0] = flags_in;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [SUM_W:0] sh;
        logic           take;

        if (i > 0)
        begin : g_link
            assign vld_in[i]     = vld_reg[i];
            assign rem_in[i]     = rem_reg[i];
            assign den_in[i]     = den_reg[i];
            assign quo_in[i]     = quo_reg[i];
            assign flags_in_s[i] = flags_reg[i];
        end

        assign sh   = {rem_in[i], 1'b0};
        assign take = (sh >= {1'b0, den_in[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[i+1] <= vld_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[i+1]   <= take ? SUM_W'(sh - {1'b0, den_in[i]}) : SUM_W'(sh);
                den_reg[i+1]   <= den_in[i];
                quo_reg[i+1]   <= {quo_in[i][QW-2:0], take};
                flags_reg[i+1] <= flags_in_s[i];
            end
        end
    end

    assign vld   = vld_reg[QW];
    assign quo   = quo_reg[QW];
    assign flags = flags_reg[QW];
endmodule

FILE: hdl/rgpg_sqrt.sv
`timescale 1ns / 1ps
module rgpg_sqrt
    import rgpg_pkg::*;
#(
    parameter int unsigned F = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  rgpg_ctl_t     ctl,
    input  logic [2*F-1:0] rad,
    input  rgpg_flags_t   flags_in,
    output logic          vld,
    output logic [F-1:0]  root,
    output rgpg_flags_t   flags
);
    localparam int unsigned RW = F + 2;
    localparam int unsigned CW = F + 4;

    // two radicand bits per stage, one root bit out
    logic           vld_reg   [1:F];
    logic [RW-1:0]  rem_reg   [1:F];
    logic [F-1:0]   root_reg  [1:F];
    logic [2*F-1:0] rad_reg   [1:F];
    rgpg_flags_t    flags_reg [1:F];

    logic           vld_in    [0:F-1];
    logic [RW-1:0]  rem_in    [0:F-1];
    logic [F-1:0]   root_in   [0:F-1];
    logic [2*F-1:0] rad_in    [0:F-1];
    rgpg_flags_t    flags_in_s[0:F-1];

    assign vld_in[0]     = ctl.vld;
    assign rem_in[0]     = '0;
    assign root_in[0]    = '0;
    assign rad_in[0]     = rad;
    assign flags_in_s[0] = flags_in;

    for (genvar i = 0; i < F; i++)
    begin : g_stage
        logic [CW-1:0] cat;
        logic [CW-1:0] trial;
        logic          take;

        if (i > 0)
        begin : g_link
            assign vld_in[i]     = vld_reg[i];
            assign rem_in[i]     = rem_reg[i];
            assign root_in[i]    = root_reg[i];
            assign rad_in[i]     = rad_reg[i];
            assign flags_in_s[i] = flags_reg[i];
        end

        assign cat   = {rem_in[i], rad_in[i][2*F-1-2*i -: 2]};
        assign trial = CW'({root_in[i], 2'b01});
        assign take  = (cat >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[i+1] <= vld_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[i+1]   <= take ? RW'(cat - trial) : RW'(cat);
                root_reg[i+1]  <= {root_in[i][F-2:0], take};
                rad_reg[i+1]   <= rad_in[i];
                flags_reg[i+1] <= flags_in_s[i];
            end
        end
    end

    assign vld   = vld_reg[F];
    assign root  = root_reg[F];
    assign flags = flags_reg[F];
endmodule

FILE: hdl/rgpg_shade.sv
`timescale 1ns / 1ps
module rgpg_shade
    import rgpg_pkg::*;
#(
    parameter int unsigned F = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rgpg_ctl_t         ctl,
    input  logic [F-1:0]      root,
    input  rgpg_flags_t       flags_in,
    output logic              vld,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green
);
    localparam int unsigned DW = F + 1;
    localparam int unsigned CW = F + 3;
    localparam int unsigned PW = F + 10;
    localparam int unsigned HW = PW - (F + 1);

    logic [DW-1:0] one;
    logic [DW-1:0] d_val;
    logic [CW-1:0] five_d;
    logic [CW-1:0] two_one;
    logic [HW-1:0] red_hi;
    logic [HW-1:0] grn_hi;

    logic [2:0]        vld_reg;
    logic [DW-1:0]     glow_reg;
    logic [CW-1:0]     core_reg;
    logic              zero1_reg;
    logic [PW-1:0]     redp_reg;
    logic [PW-1:0]     grnp_reg;
    logic              zero2_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;

    always_comb
    begin
        one     = DW'(1) << F;
        two_one = CW'(1) << (F + 1);
        d_val   = flags_in.sat ? one : DW'(root);
        five_d  = CW'(d_val) * CW'(5);
        red_hi  = HW'(redp_reg >> (F + 1));
        grn_hi  = HW'(grnp_reg >> (F + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[1:0], ctl.vld};
        end
    end

    // red = 51*(glow + 5*core2) / 2^(F+1), green = 255*(2*glow + core2) / 2^(F+1)
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            glow_reg  <= one - d_val;
            core_reg  <= (five_d < two_one) ? (two_one - five_d) : '0;
            zero1_reg <= flags_in.zero;
            redp_reg  <= (PW'(glow_reg) + PW'(core_reg) * PW'(5)) * PW'(51);
            grnp_reg  <= (PW'({glow_reg, 1'b0}) + PW'(core_reg)) * PW'(255);
            zero2_reg <= zero1_reg;
            red_reg   <= zero2_reg ? '0 : ((red_hi > HW'(255)) ? '1 : CHAN_W'(red_hi));
            green_reg <= zero2_reg ? '0 : ((grn_hi > HW'(255)) ? '1 : CHAN_W'(grn_hi));
        end
    end

    assign vld   = vld_reg[2];
    assign red   = red_reg;
    assign green = green_reg;
endmodule

FILE: hdl/radial_glow_pixel_generator.sv
`timescale 1ns / 1ps
// channel | dir | beat
// pixel   | in  | pixel_x, pixel_y
// color   | out | red, green, blue, alpha
// APB     | in  | image_width @ 0x0, image_height @ 0x4
//
// One pixel per clock unless a waiting output beat holds the pipe; the stages are:
// three geometry stages, one divider stage per quotient bit (2*DIST_FRAC_BITS),
// one square root stage per root bit, three shading stages.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits and sets both dimensions to 1.
module radial_glow_pixel_generator
    import rgpg_pkg::*;
#(
    parameter int unsigned DIST_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    rgpg_pix_if.sink          pixel,
    rgpg_rgba_if.source       color,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int unsigned QW = 2 * DIST_FRAC_BITS;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    reg_idx_t         idx;
    rgpg_ctl_t        ctl_geom;
    rgpg_ctl_t        ctl_div;
    rgpg_ctl_t        ctl_sqrt;
    rgpg_ctl_t        ctl_shade;
    logic             adv;

    logic                      geom_vld;
    logic [SUM_W-1:0]          geom_num;
    logic [SUM_W-1:0]          geom_den;
    rgpg_flags_t               geom_flags;
    logic                      div_vld;
    logic [QW-1:0]             div_quo;
    rgpg_flags_t               div_flags;
    logic                      sqrt_vld;
    logic [DIST_FRAC_BITS-1:0] sqrt_root;
    rgpg_flags_t               sqrt_flags;
    logic [CHAN_W-1:0]         red;

    assign idx    = reg_idx_t'(paddr[2]);
    assign pready = 1'b1;
    assign prdata = (idx == REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // hold the whole pipe while a finished beat waits
    assign adv         = !color.valid || color.ready;
    assign pixel.ready = adv;
    assign ctl_geom    = '{en: adv, vld: pixel.valid};
    assign ctl_div     = '{en: adv, vld: geom_vld};
    assign ctl_sqrt    = '{en: adv, vld: div_vld};
    assign ctl_shade   = '{en: adv, vld: sqrt_vld};

    rgpg_geom u_geom
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_geom),
        .px         (pixel.pixel_x),
        .py         (pixel.pixel_y),
        .width_raw  (width_reg),
        .height_raw (height_reg),
        .vld        (geom_vld),
        .num        (geom_num),
        .den        (geom_den),
        .flags      (geom_flags)
    );

    rgpg_div #(.QW(QW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_div),
        .num      (geom_num),
        .den      (geom_den),
        .flags_in (geom_flags),
        .vld      (div_vld),
        .quo      (div_quo),
        .flags    (div_flags)
    );

    rgpg_sqrt #(.F(DIST_FRAC_BITS)) u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_sqrt),
        .rad      (div_quo),
        .flags_in (div_flags),
        .vld      (sqrt_vld),
        .root     (sqrt_root),
        .flags    (sqrt_flags)
    );

    rgpg_shade #(.F(DIST_FRAC_BITS)) u_shade
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_shade),
        .root     (sqrt_root),
        .flags_in (sqrt_flags),
        .vld      (color.valid),
        .red      (red),
        .green    (color.green)
    );

    assign color.red   = red;
    assign color.blue  = red;
    assign color.alpha = ALPHA_OPAQUE;
endmodule

FILE: hdl/rgpg_check.sv
`timescale 1ns / 1ps
module rgpg_check
    import rgpg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAN_W-1:0] red,
    input logic [CHAN_W-1:0] green,
    input logic [CHAN_W-1:0] blue,
    input logic [CHAN_W-1:0] alpha
);
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alpha == ALPHA_OPAQUE))
        else $error("alpha not opaque");

    a_red_blue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red == blue) && (green >= red))
        else $error("channel relation broken");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output side");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(red) && $stable(green))
        else $error("stalled beat changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> in_valid)
        else $error("waiting input beat dropped");
endmodule

bind radial_glow_pixel_generator rgpg_check u_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (color.valid),
    .out_ready (color.ready),
    .red       (color.red),
    .green     (color.green),
    .blue      (color.blue),
    .alpha     (color.alpha)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rgpg_pkg::*;

    localparam int unsigned FRAC    = 16;
    localparam int unsigned LATENCY = 3 * FRAC + 6;
    localparam int unsigned N_RAND  = 1950;
    localparam int unsigned LIMIT   = 400000;

    typedef struct packed
    {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

    typedef struct
    {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        bit               typed;
        rgba_t            color;
    } pix_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    rgpg_pix_if  pixel ();
    rgpg_rgba_if color ();

    radial_glow_pixel_generator #(.DIST_FRAC_BITS(FRAC)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel.sink),
        .color   (color.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    rgba_t            expected_colors[$];
    pix_row_t         rows[$];
    int unsigned      mismatches;
    int unsigned      cycles;
    bit               sink_steady;
    bit               src_steady;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIMENSION)
            return MAX_DIMENSION;
        return raw;
    endfunction

    function automatic rgba_t glow_color(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        longint unsigned one;
        longint unsigned cx;
        longint unsigned cy;
        longint unsigned den;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned q;
        longint unsigned d;
        longint unsigned root;
        longint unsigned bitv;
        longint unsigned glow;
        longint unsigned c2;
        longint unsigned r;
        longint unsigned g;
        rgba_t           res;
        one = 64'd1 << FRAC;
        cx  = clamp_dim(width_reg) - 1;
        cy  = clamp_dim(height_reg) - 1;
        den = cx * cx + cy * cy;
        ax  = (2 * px >= cx) ? 2 * px - cx : cx - 2 * px;
        ay  = (2 * py >= cy) ? 2 * py - cy : cy - 2 * py;
        num = ax * ax + ay * ay;
        r   = 0;
        g   = 0;
        if (den != 0)
        begin
            if (num >= den)
                d = one;
            else
            begin
                rem = num;
                q   = 0;
                for (int i = 0; i < 2 * FRAC; i++)
                begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= den)
                    begin
                        rem = rem - den;
                        q   = q | 1;
                    end
                end
                root = 0;
                bitv = 64'd1 << 62;
                while (bitv > q)
                    bitv = bitv >> 2;
                while (bitv != 0)
                begin
                    if (q >= root + bitv)
                    begin
                        q    = q - (root + bitv);
                        root = (root >> 1) + bitv;
                    end
                    else
                        root = root >> 1;
                    bitv = bitv >> 2;
                end
                d = (root > one) ? one : root;
            end
            glow = one - d;
            c2   = (5 * d < 2 * one) ? 2 * one - 5 * d : 0;
            r    = (255 * (2 * glow + 10 * c2)) / (20 * one);
            g    = (255 * (2 * glow + c2)) / (2 * one);
            if (r > 255)
                r = 255;
            if (g > 255)
                g = 255;
        end
        res.red   = r[7:0];
        res.green = g[7:0];
        res.blue  = r[7:0];
        res.alpha = ALPHA_OPAQUE;
        return res;
    endfunction

    task automatic add_row(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, bit typed, rgba_t c);
        pix_row_t r;
        r.x     = x;
        r.y     = y;
        r.typed = typed;
        r.color = c;
        rows.insert(rows.size(), r);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[DIM_W-1:0];
        else
            height_reg = value[DIM_W-1:0];
        if (prdata !== 32'(value[DIM_W-1:0]))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register readback: expected %h got %h",
                         32'(value[DIM_W-1:0]), prdata);
        end
        @(negedge clk);
    endtask

    // drain the pipe before touching registers
    task automatic wait_idle();
        pixel.valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4)
            @(negedge clk);
    endtask

    task automatic set_size(logic [31:0] w, logic [31:0] h);
        wait_idle();
        apb_write(REG_IMAGE_WIDTH, w);
        apb_write(REG_IMAGE_HEIGHT, h);
    endtask

    // valid stays high after the beat; the next call or the caller drops it
    task automatic send_pixel(pix_row_t row);
        rgba_t exp_c;
        while (!src_steady && $urandom_range(99) < 32)
        begin
            pixel.valid <= 1'b0;
            @(negedge clk);
        end
        exp_c = glow_color(row.x, row.y);
        if (row.typed && exp_c != row.color)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row (%0d,%0d): typed %h model %h", row.x, row.y,
                         row.color, exp_c);
        end
        pixel.valid   <= 1'b1;
        pixel.pixel_x <= row.x;
        pixel.pixel_y <= row.y;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        expected_colors.insert(expected_colors.size(), exp_c);
        @(negedge clk);
    endtask

    task automatic send_random(int unsigned n, int unsigned wmax, int unsigned hmax);
        pix_row_t row;
        row.typed = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
            begin
                row.x = PIX_W'($urandom_range(wmax - 1));
                row.y = PIX_W'($urandom_range(hmax - 1));
            end
            else
            begin
                row.x = PIX_W'($urandom);
                row.y = PIX_W'($urandom);
            end
            send_pixel(row);
        end
    endtask

    // sample at the rising edge, change ready at the falling edge
    always @(posedge clk)
    begin
        rgba_t got;
        rgba_t want;
        if (rst_n && color.valid && color.ready)
        begin
            got = '{color.red, color.green, color.blue, color.alpha};
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %h", got);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (got.red !== want.red || got.green !== want.green
                    || got.blue !== want.blue || got.alpha !== want.alpha)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    always @(negedge clk)
        color.ready <= sink_steady ? 1'b1 : ($urandom_range(99) >= 32);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        rgba_t    black;
        rgba_t    peak;
        black = '{8'd0, 8'd0, 8'd0, ALPHA_OPAQUE};
        peak  = '{8'd255, 8'd255, 8'd255, ALPHA_OPAQUE};
        mismatches    = 0;
        cycles        = 0;
        sink_steady   = 1'b0;
        src_steady    = 1'b0;
        width_reg     = 1;
        height_reg    = 1;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pixel.valid   = 1'b0;
        pixel.pixel_x = '0;
        pixel.pixel_y = '0;
        color.ready   = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 1x1 after reset: black everywhere
        add_row(12'd0, 12'd0, 1'b1, black);
        add_row(12'hFFF, 12'hFFF, 1'b1, black);
        foreach (rows[i])
            send_pixel(rows[i]);
        rows.delete();

        set_size(3, 3);
        add_row(12'd1, 12'd1, 1'b1, peak);
        add_row(12'd0, 12'd0, 1'b1, black);
        add_row(12'd2, 12'd2, 1'b1, black);
        add_row(12'd0, 12'd1, 1'b0, black);
        add_row(12'd1, 12'd2, 1'b0, black);
        add_row(12'd2, 12'd0, 1'b1, black);
        add_row(12'hFFF, 12'd1, 1'b1, black);
        foreach (rows[i])
            send_pixel(rows[i]);
        rows.delete();

        set_size(13'h1FFF, 4096);
        add_row(12'd0, 12'd0, 1'b1, black);
        add_row(12'hFFF, 12'hFFF, 1'b1, black);
        add_row(12'd2048, 12'd2048, 1'b0, black);
        add_row(12'd2047, 12'd2048, 1'b0, black);
        add_row(12'd1000, 12'd3000, 1'b0, black);
        add_row(12'hAAA, 12'h555, 1'b0, black);
        foreach (rows[i])
            send_pixel(rows[i]);
        rows.delete();

        set_size(0, 5);
        add_row(12'd0, 12'd2, 1'b0, black);
        add_row(12'd0, 12'd1, 1'b0, black);
        add_row(12'd0, 12'd4, 1'b1, black);
        foreach (rows[i])
            send_pixel(rows[i]);
        rows.delete();

        set_size(64, 48);
        send_random(500, 64, 48);
        // pause until everything is out
        pixel.valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        sink_steady = 1'b1;
        src_steady  = 1'b1;
        send_random(300, 64, 48);
        sink_steady = 1'b0;
        src_steady  = 1'b0;
        set_size(2, 2);
        send_random(150, 2, 2);
        set_size(4096, 1);
        send_random(300, 4096, 1);
        set_size($urandom_range(1, 4096), $urandom_range(1, 4096));
        send_random(400, clamp_dim(width_reg), clamp_dim(height_reg));
        set_size(4096, 4096);
        send_random(300, 4096, 4096);

        pixel.valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4)
            @(negedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
